FILE: rtl/omwd_pkg.sv
// Shared widths, types, constants and helpers of the omni wheel mixer.
package omwd_pkg;

   // Width of one speed word on the request and response channels
   localparam int SPEED_BITS = 16;
   // Limit register width: the limit is unsigned and below full scale
   localparam int LIMIT_BITS = SPEED_BITS - 1;
   // Exact wheel sums need two bits above a speed word
   localparam int WHEEL_BITS = SPEED_BITS + 2;
   localparam int MAG_BITS   = SPEED_BITS + 1;
   // Magnitude times limit, the divider's dividend
   localparam int PROD_BITS  = MAG_BITS + LIMIT_BITS;

   // Q2.14 coefficient for 1/cos30
   localparam int COEF_BITS  = 16;
   localparam int Q_SHIFT    = 14;
   localparam int PRODY_BITS = SPEED_BITS + COEF_BITS;
   localparam logic signed [COEF_BITS-1:0] COEF_INV_COS30 = COEF_BITS'(18919);
   localparam logic signed [PRODY_BITS-1:0] Q_ROUND = PRODY_BITS'((1 << Q_SHIFT) - 1);

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1000);

   typedef logic signed [SPEED_BITS-1:0] speed_type;
   typedef logic signed [WHEEL_BITS-1:0] wheel_type;
   typedef logic signed [PRODY_BITS-1:0] prody_type;
   typedef logic        [MAG_BITS-1:0]   mag_type;
   typedef logic        [LIMIT_BITS-1:0] limit_type;
   typedef logic        [PROD_BITS-1:0]  prod_type;

   // Absolute value of an exact wheel sum
   function automatic mag_type mag_of(input wheel_type v);
      wheel_type n;
      n = -v;
      return v[WHEEL_BITS-1] ? n[MAG_BITS-1:0] : v[MAG_BITS-1:0];
   endfunction

   // Signed speed from a scaled magnitude and the original sign
   function automatic speed_type apply_sign(input logic neg, input limit_type q);
      speed_type s;
      s = speed_type'({1'b0, q});
      return neg ? -s : s;
   endfunction

endpackage

FILE: rtl/omwd_if.sv
// Valid/ready channel interfaces for requests, responses and the limit register.
interface omwd_req_if;
   logic                valid;
   logic                ready;
   omwd_pkg::speed_type x_speed;
   omwd_pkg::speed_type y_speed;
   omwd_pkg::speed_type angular_speed;

   modport source (output valid, output x_speed, output y_speed, output angular_speed,
                   input ready);
   modport sink   (input valid, input x_speed, input y_speed, input angular_speed,
                   output ready);
endinterface

interface omwd_rsp_if;
   logic                valid;
   logic                ready;
   omwd_pkg::speed_type wheel_a_speed;
   omwd_pkg::speed_type wheel_b_drive;
   omwd_pkg::speed_type wheel_c_speed;
   logic                was_scaled;

   modport source (output valid, output wheel_a_speed, output wheel_b_drive,
                   output wheel_c_speed, output was_scaled, input ready);
   modport sink   (input valid, input wheel_a_speed, input wheel_b_drive,
                   input wheel_c_speed, input was_scaled, output ready);
endinterface

interface omwd_csr_if;
   logic                valid;
   logic                ready;
   omwd_pkg::limit_type max_wheel_speed;

   modport source (output valid, output max_wheel_speed, input ready);
   modport sink   (input valid, input max_wheel_speed, output ready);
endinterface

FILE: rtl/omwd_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, quotient below 2^LIMIT_BITS.
module omwd_div_pipe (
   input  logic                clock,
   input  logic                en,
   input  omwd_pkg::prod_type  dividend,
   input  omwd_pkg::mag_type   divisor,
   output omwd_pkg::limit_type quotient
);

   localparam int STEPS = omwd_pkg::LIMIT_BITS;
   localparam int MW    = omwd_pkg::MAG_BITS;

   // Partial remainder, unused dividend bits and divisor ride along each stage
   omwd_pkg::mag_type   rem_ff [STEPS-1];
   omwd_pkg::limit_type low_ff [STEPS-1];
   omwd_pkg::mag_type   den_ff [STEPS-1];
   omwd_pkg::limit_type quo_ff [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      omwd_pkg::mag_type   rem_src;
      omwd_pkg::limit_type low_src;
      omwd_pkg::mag_type   den_src;
      omwd_pkg::limit_type quo_src;
      logic [MW:0]         trial;
      logic [MW:0]         diff;
      logic                take;

      if (k == 0) begin : g_head
         // Upper bits start below the divisor since limit < 2^LIMIT_BITS and mag <= largest
         assign rem_src = dividend[omwd_pkg::PROD_BITS-1:STEPS];
         assign low_src = dividend[STEPS-1:0];
         assign den_src = divisor;
         assign quo_src = '0;
      end else begin : g_body
         assign rem_src = rem_ff[k-1];
         assign low_src = low_ff[k-1];
         assign den_src = den_ff[k-1];
         assign quo_src = quo_ff[k-1];
      end

      // Compare and subtract for one quotient bit
      assign trial = {rem_src, low_src[STEPS-1]};
      assign diff  = trial - {1'b0, den_src};
      assign take  = trial >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k] <= {quo_src[STEPS-2:0], take};
         end
      end

      if (k < STEPS - 1) begin : g_carry
         omwd_pkg::mag_type   rem_in;
         omwd_pkg::limit_type low_in;

         assign rem_in = take ? diff[MW-1:0] : trial[MW-1:0];
         assign low_in = low_src << 1;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               low_ff[k] <= low_in;
               den_ff[k] <= den_src;
            end
         end
      end
   end

   assign quotient = quo_ff[STEPS-1];

endmodule

FILE: rtl/omni_wheel_mixer_with_desaturation.sv
// Throughput: one word per cycle while the skid entry is empty; the mixer runs
// four stages, then the desaturation divider resolves one quotient bit per stage
// (LIMIT_BITS stages).
// A two-entry output (register plus skid); a full skid entry halts the pipeline.
// Reset (synchronous) empties the pipeline and sets max_wheel_speed to 1000.
module omni_wheel_mixer_with_desaturation (
   input  logic clock,
   input  logic reset,
   omwd_req_if.sink   req_port,
   omwd_rsp_if.source rsp_port,
   omwd_csr_if.sink   csr_port
);

   localparam int DSTAGES = omwd_pkg::LIMIT_BITS;

   // Data that travels beside the divider
   typedef struct packed {
      logic                scale;
      logic                neg_a;
      logic                neg_b;
      logic                neg_c;
      omwd_pkg::speed_type a;
      omwd_pkg::speed_type b;
      omwd_pkg::speed_type c;
   } side_type;

   typedef struct packed {
      omwd_pkg::speed_type a;
      omwd_pkg::speed_type b;
      omwd_pkg::speed_type c;
      logic                was_scaled;
   } rsp_word_type;

   logic pipe_en;

   // Limit register
   omwd_pkg::limit_type limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= omwd_pkg::LIMIT_RESET;
      end else if (csr_port.valid) begin
         limit_ff <= csr_port.max_wheel_speed;
      end
   end

   assign csr_port.ready = 1'b1;

   // Stage 1: halve x toward zero, multiply y by 1/cos30
   logic                s1_valid_ff;
   omwd_pkg::speed_type s1_x_ff, s1_w_ff, s1_tx_ff, s1_tx_in;
   omwd_pkg::prody_type s1_ty_prod_ff, s1_ty_prod_in;

   assign s1_tx_in = (req_port.x_speed >>> 1)
                   + omwd_pkg::speed_type'({1'b0, req_port.x_speed[omwd_pkg::SPEED_BITS-1]
                                                  & req_port.x_speed[0]});
   assign s1_ty_prod_in = req_port.y_speed * omwd_pkg::COEF_INV_COS30;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_port.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x_ff       <= req_port.x_speed;
         s1_w_ff       <= req_port.angular_speed;
         s1_tx_ff      <= s1_tx_in;
         s1_ty_prod_ff <= s1_ty_prod_in;
      end
   end

   // Stage 2: scale y product toward zero, form the three wheel sums
   logic                s2_valid_ff;
   omwd_pkg::wheel_type s2_a_ff, s2_b_ff, s2_c_ff, s2_a_in, s2_b_in, s2_c_in;
   omwd_pkg::prody_type s2_ty_bias;
   omwd_pkg::prody_type s2_ty_full;
   omwd_pkg::wheel_type s2_ty, s2_tx, s2_x, s2_w;

   assign s2_ty_bias = s1_ty_prod_ff
                     + (s1_ty_prod_ff[omwd_pkg::PRODY_BITS-1] ? omwd_pkg::Q_ROUND
                                                                : omwd_pkg::prody_type'(0));
   assign s2_ty_full = s2_ty_bias >>> omwd_pkg::Q_SHIFT;
   assign s2_ty      = s2_ty_full[omwd_pkg::WHEEL_BITS-1:0];
   assign s2_tx      = omwd_pkg::wheel_type'(s1_tx_ff);
   assign s2_x       = omwd_pkg::wheel_type'(s1_x_ff);
   assign s2_w       = omwd_pkg::wheel_type'(s1_w_ff);
   assign s2_a_in    = s2_w - s2_tx + s2_ty;
   assign s2_b_in    = s2_w - s2_tx - s2_ty;
   assign s2_c_in    = s2_w + s2_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_a_ff <= s2_a_in;
         s2_b_ff <= s2_b_in;
         s2_c_ff <= s2_c_in;
      end
   end

   // Stage 3: magnitudes, largest, and the desaturation decision
   logic              s3_valid_ff;
   side_type          s3_side_ff, s3_side_in;
   omwd_pkg::mag_type s3_mag_a_ff, s3_mag_b_ff, s3_mag_c_ff;
   omwd_pkg::mag_type s3_mag_a_in, s3_mag_b_in, s3_mag_c_in;
   omwd_pkg::mag_type s3_big_ff, s3_big_in, s3_big_ab;

   assign s3_mag_a_in = omwd_pkg::mag_of(s2_a_ff);
   assign s3_mag_b_in = omwd_pkg::mag_of(s2_b_ff);
   assign s3_mag_c_in = omwd_pkg::mag_of(s2_c_ff);
   assign s3_big_ab   = (s3_mag_b_in > s3_mag_a_in) ? s3_mag_b_in : s3_mag_a_in;
   assign s3_big_in   = (s3_mag_c_in > s3_big_ab) ? s3_mag_c_in : s3_big_ab;

   always_comb begin
      s3_side_in.scale = s3_big_in > omwd_pkg::mag_type'(limit_ff);
      s3_side_in.neg_a = s2_a_ff[omwd_pkg::WHEEL_BITS-1];
      s3_side_in.neg_b = s2_b_ff[omwd_pkg::WHEEL_BITS-1];
      s3_side_in.neg_c = s2_c_ff[omwd_pkg::WHEEL_BITS-1];
      // Unscaled wheels are within the limit, so they fit a speed word
      s3_side_in.a     = s2_a_ff[omwd_pkg::SPEED_BITS-1:0];
      s3_side_in.b     = s2_b_ff[omwd_pkg::SPEED_BITS-1:0];
      s3_side_in.c     = s2_c_ff[omwd_pkg::SPEED_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_side_ff  <= s3_side_in;
         s3_mag_a_ff <= s3_mag_a_in;
         s3_mag_b_ff <= s3_mag_b_in;
         s3_mag_c_ff <= s3_mag_c_in;
         s3_big_ff   <= s3_big_in;
      end
   end

   // Stage 4: magnitude times limit for each wheel
   logic               s4_valid_ff;
   side_type           s4_side_ff;
   omwd_pkg::mag_type  s4_big_ff;
   omwd_pkg::prod_type s4_prod_a_ff, s4_prod_b_ff, s4_prod_c_ff;
   omwd_pkg::prod_type s4_prod_a_in, s4_prod_b_in, s4_prod_c_in;
   omwd_pkg::prod_type s4_limit;

   assign s4_limit     = omwd_pkg::prod_type'(limit_ff);
   assign s4_prod_a_in = omwd_pkg::prod_type'(s3_mag_a_ff) * s4_limit;
   assign s4_prod_b_in = omwd_pkg::prod_type'(s3_mag_b_ff) * s4_limit;
   assign s4_prod_c_in = omwd_pkg::prod_type'(s3_mag_c_ff) * s4_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s4_side_ff   <= s3_side_ff;
         s4_big_ff    <= s3_big_ff;
         s4_prod_a_ff <= s4_prod_a_in;
         s4_prod_b_ff <= s4_prod_b_in;
         s4_prod_c_ff <= s4_prod_c_in;
      end
   end

   // Divider stages: product / largest, one lane per wheel
   omwd_pkg::limit_type quo_a, quo_b, quo_c;

   omwd_div_pipe u_div_a (
      .clock    (clock),
      .en       (pipe_en),
      .dividend (s4_prod_a_ff),
      .divisor  (s4_big_ff),
      .quotient (quo_a)
   );

   omwd_div_pipe u_div_b (
      .clock    (clock),
      .en       (pipe_en),
      .dividend (s4_prod_b_ff),
      .divisor  (s4_big_ff),
      .quotient (quo_b)
   );

   omwd_div_pipe u_div_c (
      .clock    (clock),
      .en       (pipe_en),
      .dividend (s4_prod_c_ff),
      .divisor  (s4_big_ff),
      .quotient (quo_c)
   );

   // Valid bits and sideband aligned with the divider stages
   logic     dv_valid_ff [DSTAGES];
   side_type dv_side_ff  [DSTAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DSTAGES; i++) begin
            dv_valid_ff[i] <= 1'b0;
         end
      end else if (pipe_en) begin
         dv_valid_ff[0] <= s4_valid_ff;
         for (int i = 1; i < DSTAGES; i++) begin
            dv_valid_ff[i] <= dv_valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dv_side_ff[0] <= s4_side_ff;
         for (int i = 1; i < DSTAGES; i++) begin
            dv_side_ff[i] <= dv_side_ff[i-1];
         end
      end
   end

   // Final select: scaled or pass-through, wheel B negated for its motor
   side_type            last_side;
   logic                last_valid;
   rsp_word_type        last_word;
   omwd_pkg::speed_type last_b;

   assign last_side  = dv_side_ff[DSTAGES-1];
   assign last_valid = dv_valid_ff[DSTAGES-1];

   always_comb begin
      last_word.was_scaled = last_side.scale;
      if (last_side.scale) begin
         last_word.a = omwd_pkg::apply_sign(last_side.neg_a, quo_a);
         last_b      = omwd_pkg::apply_sign(last_side.neg_b, quo_b);
         last_word.c = omwd_pkg::apply_sign(last_side.neg_c, quo_c);
      end else begin
         last_word.a = last_side.a;
         last_b      = last_side.b;
         last_word.c = last_side.c;
      end
      last_word.b = -last_b;
   end

   // Output register plus skid entry
   logic         rsp_valid_ff, skid_valid_ff;
   rsp_word_type rsp_ff, skid_ff;

   assign pipe_en        = !skid_valid_ff;
   assign req_port.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_port.ready) begin
         rsp_valid_ff  <= skid_valid_ff || last_valid;
         skid_valid_ff <= 1'b0;
      end else if (last_valid && pipe_en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_port.ready) begin
         rsp_ff <= skid_valid_ff ? skid_ff : last_word;
      end else if (last_valid && pipe_en) begin
         skid_ff <= last_word;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.wheel_a_speed = rsp_ff.a;
   assign rsp_port.wheel_b_drive = rsp_ff.b;
   assign rsp_port.wheel_c_speed = rsp_ff.c;
   assign rsp_port.was_scaled    = rsp_ff.was_scaled;

`ifndef SYNTHESIS
   // Skid entry is only occupied behind a held output word
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word without an output word");

   // Skid fills only when the output word was stalled
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_port.ready))
      else $error("skid filled while output was free");

   // Scaling never reaches the divider with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && s4_side_ff.scale) |-> (s4_big_ff != '0))
      else $error("desaturation with zero largest magnitude");
`endif

endmodule
